/* rtl/core/assert_macros.svh */
// assertion macros for the list engine core
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition never holds on a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/bole_pkg.sv */
// shared types and codes for the bounded ordered list engine
// no dependencies; imported by the queue, back end and top level
`default_nettype none

package bole_pkg;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// classified operation handed from front to back
	typedef enum logic [3:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_INSERT_KEY,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_REMOVE,
		OP_CLEAR,
		OP_COUNT,
		OP_READ_ALL
	} op_t;

	// one queued operation
	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
		logic signed [31:0] key;
		logic [5:0]         keep;
	} q_item_t;

	// queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bole_if.sv */
// valid/ready channel interfaces for command and result transfers
// no dependencies
`default_nettype none

interface bole_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         command;
	logic signed [31:0] item_value;
	logic signed [31:0] match_key;
	logic [5:0]         position;

	modport source (output valid, command, item_value, match_key, position, input ready);
	modport sink (input valid, command, item_value, match_key, position, output ready);
endinterface

interface bole_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] result_value;
	logic               last;

	modport source (output valid, status, result_value, last, input ready);
	modport sink (input valid, status, result_value, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/bounded_ordered_list_engine_core.sv */
// Bounded ordered list engine: keeps up to CAPACITY signed 32-bit entries in order.
// Commands arrive on req (valid/ready); a transfer carries command, item_value,
// match_key and position. Results leave on rsp as status, result_value and last;
// every command gives one result except read_all, which gives one per entry,
// front first, with last set on the final one. Unused command codes are taken
// and give no result.
// A decoder feeds a two-entry queue, so commands are taken while the back end
// works. The back end holds the entries in a store with one write port and one
// registered read port, and its work is done as sweeps over that store:
//   clear, count and status-only answers need no sweep; pop_back and push_back move no entries
//   push_front, pop_front, remove and insert shift the entries behind the slot
//   insert first scans for the key from the front, then shifts
//   read_all reads each entry and then emits it as a result
// A transfer passes the queue, the sequencer and the result register before its first result.
// After reset the list is empty; no clearing pass is run.
// A stalled rsp holds its result; the back end waits and the queue then fills,
// after which req is no longer ready.
// depends on bole_pkg, bole_if, bole_front, bole_fifo, bole_back, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bounded_ordered_list_engine_core #(
	parameter int CAPACITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bole_in_if.sink    req,
	bole_out_if.source rsp
);
	import bole_pkg::*;

	logic       push_valid;
	logic       push_ready;
	q_item_t    push_item;
	logic       q_valid;
	logic       q_ready;
	q_item_t    q_item;
	fifo_stat_t fifo_stat;

	// decode
	bole_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decoupling queue
	bole_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item),
		.stat       (fifo_stat)
	);

	// list store and sequencer
	bole_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.rsp     (rsp)
	);

	// checks
	`ASSERT_NEVER(a_push_when_full, clk, arst_n, push_valid && push_ready && fifo_stat.full, "queue push while full")
	`ASSERT_AR(a_mid_run_ok, clk, arst_n, rsp.valid && !rsp.last |-> rsp.status == ST_OK, "non-final result with error status")
	`ASSERT_AR(a_empty_result, clk, arst_n, rsp.valid && rsp.status == ST_EMPTY |-> rsp.last && rsp.result_value == 32'sd0, "empty status with payload")
	`ASSERT_AR(a_pop_idle_queue, clk, arst_n, q_ready && fifo_stat.empty |-> !q_valid, "back end sees item from empty queue")

endmodule

`default_nettype wire

/* rtl/core/bole_front.sv */
// front end: accepts command transfers, decodes them and drops unused codes
// depends on bole_pkg and bole_in_if
`default_nettype none

module bole_front (
	bole_in_if.sink           req,
	output logic              push_valid,
	input  logic              push_ready,
	output bole_pkg::q_item_t push_item
);
	import bole_pkg::*;

	localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
	localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
	localparam logic [3:0] CMD_INSERT_KEY = 4'd2;
	localparam logic [3:0] CMD_POP_FRONT  = 4'd3;
	localparam logic [3:0] CMD_POP_BACK   = 4'd4;
	localparam logic [3:0] CMD_REMOVE     = 4'd5;
	localparam logic [3:0] CMD_CLEAR      = 4'd6;
	localparam logic [3:0] CMD_COUNT      = 4'd7;
	localparam logic [3:0] CMD_READ_ALL   = 4'd8;

	logic cmd_ok;
	op_t  op;

	// command decode; unused codes are taken and discarded
	always_comb begin
		cmd_ok = 1'b1;
		op     = OP_PUSH_FRONT;
		unique case (req.command)
			CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
			CMD_PUSH_BACK:  op = OP_PUSH_BACK;
			CMD_INSERT_KEY: op = OP_INSERT_KEY;
			CMD_POP_FRONT:  op = OP_POP_FRONT;
			CMD_POP_BACK:   op = OP_POP_BACK;
			CMD_REMOVE:     op = OP_REMOVE;
			CMD_CLEAR:      op = OP_CLEAR;
			CMD_COUNT:      op = OP_COUNT;
			CMD_READ_ALL:   op = OP_READ_ALL;
			default:        cmd_ok = 1'b0;
		endcase
	end

	// queue entry; removal keeps at least one leading entry
	always_comb begin
		push_item.op    = op;
		push_item.value = req.item_value;
		push_item.key   = req.match_key;
		push_item.keep  = (req.position == 6'd0) ? 6'd1 : req.position;
	end

	assign req.ready  = push_ready;
	assign push_valid = req.valid && cmd_ok;

endmodule

`default_nettype wire

/* rtl/core/bole_fifo.sv */
// two-entry queue between the front end and the back end
// depends on bole_pkg
`default_nettype none

module bole_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  bole_pkg::q_item_t    push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output bole_pkg::q_item_t    pop_item,
	output bole_pkg::fifo_stat_t stat
);
	import bole_pkg::*;

	localparam int Depth = 2;
	localparam int PW    = $clog2(Depth);
	localparam int FW    = $clog2(Depth + 1);

	q_item_t        slot_q [Depth];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [FW-1:0]  fill_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (fill_q != FW'(Depth));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign stat.full  = !push_ready;
	assign stat.empty = !pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bole_back.sv */
// back end: entry store, list count and the sequencer that walks the store
// depends on bole_pkg and bole_out_if
`default_nettype none

module bole_back #(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  bole_pkg::q_item_t q_item,
	bole_out_if.source        rsp
);
	import bole_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SHIFT    = 3'd1;
	localparam logic [2:0] S_PLACE    = 3'd2;
	localparam logic [2:0] S_RESP     = 3'd3;
	localparam logic [2:0] S_RD_ISSUE = 3'd4;
	localparam logic [2:0] S_RD_EMIT  = 3'd5;
	localparam logic [2:0] S_SC_ISSUE = 3'd6;
	localparam logic [2:0] S_SC_CHK   = 3'd7;

	logic signed [31:0] store_q [CAPACITY];
	logic signed [31:0] rdata_q;

	logic [2:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rem_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      src_q;
	logic [AW-1:0]      dst_q;
	logic               pend_q;
	logic               up_q;
	logic signed [31:0] val_q;
	logic signed [31:0] key_q;
	logic [1:0]         resp_status_q;
	logic signed [31:0] resp_value_q;

	logic               ov_q;
	logic [1:0]         o_status_q;
	logic signed [31:0] o_value_q;
	logic               o_last_q;

	logic [CW-1:0]      cnt_m1;
	logic               full;
	logic               empty;
	logic [AW-1:0]      idx_p1;
	logic               is_last;
	logic               keep_oor;
	logic [AW-1:0]      st_idx;
	logic               st_up;
	logic [CW-1:0]      st_idx_cw;
	logic [CW-1:0]      sh_rem;
	logic [AW-1:0]      sh_src;
	logic               out_free;
	logic               out_load;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      mem_waddr;
	logic [AW-1:0]      mem_raddr;
	logic signed [31:0] mem_wdata;

	// list level flags and walk position
	assign cnt_m1   = count_q - 1'b1;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign idx_p1   = idx_q + 1'b1;
	assign is_last  = ((CW'(idx_q) + 1'b1) == count_q);
	assign keep_oor = (8'(q_item.keep) >= 8'(count_q));

	// start index and direction of a shift pass
	always_comb begin
		st_idx = '0;
		st_up  = 1'b1;
		if (state_q == S_SC_CHK) begin
			st_idx = idx_p1;
		end else begin
			unique case (q_item.op)
				OP_PUSH_BACK: st_idx = count_q[AW-1:0];
				OP_POP_FRONT: st_up = 1'b0;
				OP_POP_BACK: begin
					st_idx = cnt_m1[AW-1:0];
					st_up  = 1'b0;
				end
				OP_REMOVE: begin
					st_idx = q_item.keep[AW-1:0];
					st_up  = 1'b0;
				end
				default: st_idx = '0;
			endcase
		end
	end

	// moves needed and first source entry
	assign st_idx_cw = CW'(st_idx);
	assign sh_rem    = st_up ? (count_q - st_idx_cw) : (cnt_m1 - st_idx_cw);
	assign sh_src    = st_up ? cnt_m1[AW-1:0] : (st_idx + 1'b1);

	assign q_ready  = (state_q == S_IDLE);
	assign out_free = !ov_q || rsp.ready;
	assign out_load = out_free && ((state_q == S_RESP) || (state_q == S_RD_EMIT));

	// store port control
	always_comb begin
		mem_we    = ((state_q == S_SHIFT) && pend_q) || (state_q == S_PLACE);
		mem_waddr = (state_q == S_PLACE) ? idx_q : dst_q;
		mem_wdata = (state_q == S_PLACE) ? val_q : rdata_q;
		mem_re    = ((state_q == S_SHIFT) && (rem_q != '0)) ||
			(state_q == S_RD_ISSUE) || (state_q == S_SC_ISSUE);
		mem_raddr = (state_q == S_SHIFT) ? src_q : idx_q;
	end

	// entry store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= store_q[mem_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			rem_q         <= '0;
			idx_q         <= '0;
			src_q         <= '0;
			dst_q         <= '0;
			pend_q        <= 1'b0;
			up_q          <= 1'b1;
			val_q         <= '0;
			key_q         <= '0;
			resp_status_q <= ST_OK;
			resp_value_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						val_q        <= q_item.value;
						key_q        <= q_item.key;
						resp_value_q <= '0;
						unique case (q_item.op)
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								if (full) begin
									resp_status_q <= ST_FULL;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= st_idx;
									rem_q   <= sh_rem;
									src_q   <= sh_src;
									up_q    <= st_up;
									pend_q  <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							OP_INSERT_KEY: begin
								if (full) begin
									resp_status_q <= ST_FULL;
									state_q       <= S_RESP;
								end else if (empty) begin
									resp_status_q <= ST_NOT_FOUND;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= '0;
									state_q <= S_SC_ISSUE;
								end
							end
							OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
								if (empty) begin
									resp_status_q <= ST_EMPTY;
									state_q       <= S_RESP;
								end else if ((q_item.op == OP_REMOVE) && keep_oor) begin
									resp_status_q <= ST_NOT_FOUND;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= st_idx;
									rem_q   <= sh_rem;
									src_q   <= sh_src;
									up_q    <= st_up;
									pend_q  <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							OP_CLEAR: begin
								count_q       <= '0;
								resp_status_q <= ST_OK;
								state_q       <= S_RESP;
							end
							OP_COUNT: begin
								resp_status_q <= ST_OK;
								resp_value_q  <= 32'(count_q);
								state_q       <= S_RESP;
							end
							OP_READ_ALL: begin
								if (empty) begin
									resp_status_q <= ST_EMPTY;
									state_q       <= S_RESP;
								end else begin
									idx_q   <= '0;
									state_q <= S_RD_ISSUE;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// pipelined copy: read one entry, write it in the following cycle
				S_SHIFT: begin
					pend_q <= (rem_q != '0);
					dst_q  <= up_q ? (src_q + 1'b1) : (src_q - 1'b1);
					if (rem_q != '0) begin
						src_q <= up_q ? (src_q - 1'b1) : (src_q + 1'b1);
						rem_q <= rem_q - 1'b1;
					end else if (!pend_q) begin
						if (up_q) begin
							state_q <= S_PLACE;
						end else begin
							count_q       <= cnt_m1;
							resp_status_q <= ST_OK;
							state_q       <= S_RESP;
						end
					end
				end
				S_PLACE: begin
					count_q       <= count_q + 1'b1;
					resp_status_q <= ST_OK;
					state_q       <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RD_ISSUE: state_q <= S_RD_EMIT;
				S_RD_EMIT: begin
					if (out_free) begin
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_p1;
							state_q <= S_RD_ISSUE;
						end
					end
				end
				S_SC_ISSUE: state_q <= S_SC_CHK;
				// key compare; a hit opens a gap after the matching entry
				S_SC_CHK: begin
					if (rdata_q == key_q) begin
						idx_q   <= st_idx;
						rem_q   <= sh_rem;
						src_q   <= sh_src;
						up_q    <= st_up;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end else if (is_last) begin
						resp_status_q <= ST_NOT_FOUND;
						state_q       <= S_RESP;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_SC_ISSUE;
					end
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_RD_EMIT) begin
				o_status_q <= ST_OK;
				o_value_q  <= rdata_q;
				o_last_q   <= is_last;
			end else begin
				o_status_q <= resp_status_q;
				o_value_q  <= resp_value_q;
				o_last_q   <= 1'b1;
			end
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.status       = o_status_q;
	assign rsp.result_value = o_value_q;
	assign rsp.last         = o_last_q;

endmodule

`default_nettype wire

/* test/bounded_ordered_list_engine_core_tb.sv */
// self-checking testbench for the bounded ordered list engine core
// mirrors the list in a small tracker class and checks every result transfer
// depends on bole_pkg, bole_if and bounded_ordered_list_engine_core
`default_nettype none

module bounded_ordered_list_engine_core_tb;
	import bole_pkg::*;

	localparam int LIST_DEPTH = 32;
	localparam int RANDOM_ITEMS = 320;
	localparam int SETTLE_CYCLES = 120;
	localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISY} mix_t;

	// one expected result transfer
	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic               last;
	} list_answer_t;

	// mirror of the list plus the answers still owed by the block
	class list_checker;
		logic signed [31:0] entries[$];
		list_answer_t       due_answers[$];
		int                 errors;
		int                 answers_seen;
		int                 full_answers;

		function new();
			errors = 0;
			answers_seen = 0;
			full_answers = 0;
		endfunction

		function void owe(logic [1:0] status, logic signed [31:0] value, logic last);
			list_answer_t a;
			a.status = status;
			a.value = value;
			a.last = last;
			due_answers.push_back(a);
			if (status == ST_FULL)
				full_answers++;
		endfunction

		// apply one accepted command to the mirror and queue its answers
		function void apply_command(logic [3:0] cmd, logic signed [31:0] val,
				logic signed [31:0] key, logic [5:0] pos);
			int hit;
			int keep;
			hit = -1;
			case (cmd)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (entries.size() >= LIST_DEPTH) begin
						owe(ST_FULL, 0, 1'b1);
					end else begin
						if (cmd == OP_PUSH_FRONT)
							entries.push_front(val);
						else
							entries.push_back(val);
						owe(ST_OK, 0, 1'b1);
					end
				end
				OP_INSERT_KEY: begin
					// fullness wins over the key search
					if (entries.size() >= LIST_DEPTH) begin
						owe(ST_FULL, 0, 1'b1);
					end else begin
						for (int i = 0; i < entries.size(); i++) begin
							if (hit < 0 && entries[i] == key)
								hit = i;
						end
						if (hit < 0) begin
							owe(ST_NOT_FOUND, 0, 1'b1);
						end else begin
							entries.insert(hit + 1, val);
							owe(ST_OK, 0, 1'b1);
						end
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (entries.size() == 0) begin
						owe(ST_EMPTY, 0, 1'b1);
					end else begin
						if (cmd == OP_POP_FRONT)
							void'(entries.pop_front());
						else
							void'(entries.pop_back());
						owe(ST_OK, 0, 1'b1);
					end
				end
				OP_REMOVE: begin
					keep = (pos < 1) ? 1 : int'(pos);
					if (entries.size() == 0) begin
						owe(ST_EMPTY, 0, 1'b1);
					end else if (keep >= entries.size()) begin
						owe(ST_NOT_FOUND, 0, 1'b1);
					end else begin
						entries.delete(keep);
						owe(ST_OK, 0, 1'b1);
					end
				end
				OP_CLEAR: begin
					entries.delete();
					owe(ST_OK, 0, 1'b1);
				end
				OP_COUNT: begin
					owe(ST_OK, 32'(entries.size()), 1'b1);
				end
				OP_READ_ALL: begin
					if (entries.size() == 0) begin
						owe(ST_EMPTY, 0, 1'b1);
					end else begin
						for (int i = 0; i < entries.size(); i++)
							owe(ST_OK, entries[i], (i == entries.size() - 1));
					end
				end
				default: begin
					// unused codes are swallowed without an answer
				end
			endcase
		endfunction

		// compare one result transfer with the oldest owed answer
		function void check_answer(logic [1:0] status, logic signed [31:0] value, logic last);
			list_answer_t a;
			answers_seen++;
			if (due_answers.size() == 0) begin
				$display("%0t: unexpected result status %0d value %0d last %0b",
					$time, status, value, last);
				errors++;
				return;
			end
			a = due_answers.pop_front();
			if (status !== a.status) begin
				$display("%0t: status mismatch expected %0d actual %0d", $time, a.status, status);
				errors++;
			end
			if (value !== a.value) begin
				$display("%0t: result_value mismatch expected %0d actual %0d",
					$time, a.value, value);
				errors++;
			end
			if (last !== a.last) begin
				$display("%0t: last mismatch expected %0b actual %0b", $time, a.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bole_in_if  req_if ();
	bole_out_if rsp_if ();

	bounded_ordered_list_engine_core #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	list_checker tracker = new();
	int burst_left = 0;
	int commands_sent = 0;
	int unused_sent = 0;

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#(8 * 1_000_000);
		$display("[bounded_ordered_list_engine_core] ERROR");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			tracker.check_answer(rsp_if.status, rsp_if.result_value, rsp_if.last);
	end

	// receiver stalls: free-running, random, or long on/off stretches
	initial begin
		int mode;
		int mode_left;
		int hold;
		logic hold_state;
		mode = 0;
		mode_left = 0;
		hold = 0;
		hold_state = 1'b1;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (mode)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
				default: begin
					if (hold == 0) begin
						hold_state = !hold_state;
						hold = hold_state ? $urandom_range(1, 10) : $urandom_range(1, 16);
					end
					hold--;
					rsp_if.ready <= hold_state;
				end
			endcase
		end
	end

	// sender pacing: bursts of random length with random gaps between them
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// one command transfer, called and returning at a falling edge
	task automatic send_command(input logic [3:0] cmd, input logic signed [31:0] val,
			input logic signed [31:0] key, input logic [5:0] pos);
		pace_sender();
		req_if.valid <= 1'b1;
		req_if.command <= cmd;
		req_if.item_value <= val;
		req_if.match_key <= key;
		req_if.position <= pos;
		do
			@(posedge clk);
		while (!req_if.ready);
		tracker.apply_command(cmd, val, key, pos);
		commands_sent++;
		if (cmd > OP_READ_ALL)
			unused_sent++;
		@(negedge clk);
	endtask

	// hold off until every owed answer has arrived
	task automatic wait_for_drain();
		req_if.valid <= 1'b0;
		while (tracker.due_answers.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// values lean on the extremes and a small range that repeats
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3, 4: return $signed(32'($urandom_range(0, 6))) - 32'sd3;
			default: return $signed($urandom);
		endcase
	endfunction

	// keys mostly hit a stored entry
	function automatic logic signed [31:0] pick_key();
		if (tracker.entries.size() > 0 && $urandom_range(0, 9) < 7)
			return tracker.entries[$urandom_range(0, tracker.entries.size() - 1)];
		return pick_value();
	endfunction

	function automatic logic [5:0] pick_position();
		if ($urandom_range(0, 4) == 0)
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, tracker.entries.size() + 1));
	endfunction

	// command mix per phase of the random part
	function automatic logic [3:0] pick_command(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GROW: begin
				if (r < 35) return OP_PUSH_FRONT;
				if (r < 70) return OP_PUSH_BACK;
				if (r < 87) return OP_INSERT_KEY;
				if (r < 91) return OP_COUNT;
				if (r < 95) return OP_READ_ALL;
				if (r < 98) return OP_POP_BACK;
				return OP_REMOVE;
			end
			MIX_SHRINK: begin
				if (r < 25) return OP_POP_FRONT;
				if (r < 50) return OP_POP_BACK;
				if (r < 78) return OP_REMOVE;
				if (r < 84) return OP_INSERT_KEY;
				if (r < 90) return OP_COUNT;
				if (r < 96) return OP_READ_ALL;
				return OP_CLEAR;
			end
			MIX_NOISY: begin
				if (r < 20) return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
				return 4'($urandom_range(OP_PUSH_FRONT, OP_READ_ALL));
			end
			default: return 4'($urandom_range(OP_PUSH_FRONT, OP_READ_ALL));
		endcase
	endfunction

	// main sequence
	initial begin
		logic [3:0] cmd;
		mix_t mix;
		int useful;
		int phase;
		int phase_len;
		req_if.valid = 1'b0;
		req_if.command = OP_COUNT;
		req_if.item_value = 32'sd0;
		req_if.match_key = 32'sd0;
		req_if.position = 6'd0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty list answers
		send_command(OP_COUNT, 0, 0, 0);
		send_command(OP_READ_ALL, 0, 0, 0);
		send_command(OP_POP_FRONT, 0, 0, 0);
		send_command(OP_POP_BACK, 0, 0, 0);
		send_command(OP_REMOVE, 0, 0, 0);
		send_command(OP_INSERT_KEY, 32'sd1, 32'sd0, 0);
		// directed: first entry from a push, then a pop that empties the list
		send_command(OP_PUSH_FRONT, 32'sh8000_0000, 0, 0);
		send_command(OP_POP_FRONT, 0, 0, 0);
		send_command(OP_PUSH_BACK, 32'sh7FFF_FFFF, 0, 0);
		send_command(OP_POP_BACK, 0, 0, 0);
		// directed: key matches, duplicates and a missing key
		send_command(OP_PUSH_BACK, 32'sd5, 0, 0);
		send_command(OP_PUSH_BACK, -32'sd1, 0, 0);
		send_command(OP_PUSH_FRONT, 32'sd0, 0, 0);
		send_command(OP_INSERT_KEY, 32'sd7, -32'sd1, 0);
		send_command(OP_INSERT_KEY, 32'sd8, 32'sd123, 0);
		send_command(OP_PUSH_BACK, 32'sd5, 0, 0);
		send_command(OP_INSERT_KEY, 32'sd9, 32'sd5, 0);
		// directed: position zero, out of range, and the tail entry
		send_command(OP_REMOVE, 0, 0, 6'd0);
		send_command(OP_REMOVE, 0, 0, 6'd63);
		send_command(OP_REMOVE, 0, 0, 6'(tracker.entries.size() - 1));
		send_command(OP_READ_ALL, 0, 0, 0);
		send_command(OP_COUNT, 0, 0, 0);
		send_command(OP_CLEAR, 0, 0, 0);
		send_command(OP_READ_ALL, 0, 0, 0);
		send_command(CMD_UNUSED_HI, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 6'h3F);

		// random phases with differing command mixes
		useful = 0;
		phase = 0;
		while (useful < RANDOM_ITEMS) begin
			mix = mix_t'(phase % 4);
			phase_len = $urandom_range(40, 70);
			for (int n = 0; n < phase_len && useful < RANDOM_ITEMS; n++) begin
				cmd = pick_command(mix);
				send_command(cmd, pick_value(), pick_key(), pick_position());
				if (cmd <= OP_READ_ALL)
					useful++;
			end
			if (phase % 3 == 1)
				wait_for_drain();
			phase++;
		end

		// drain and let any trailing work settle
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d command transfers (%0d unused codes), %0d results checked",
			commands_sent, unused_sent, tracker.answers_seen);
		$display("full answers %0d, final list length %0d",
			tracker.full_answers, tracker.entries.size());
		if (tracker.errors == 0 && tracker.due_answers.size() == 0) begin
			$display("[bounded_ordered_list_engine_core] OK");
		end else begin
			$display("[bounded_ordered_list_engine_core] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
